// ===== rtl/remc_pkg.sv =====
// ----------------------------------------------------------------------------
// remc_pkg: shared types and constants for the rotary encoder menu control
// Payload structs, menu item codes, register indexes and the quadrature table.
// ----------------------------------------------------------------------------
package remc_pkg;

  // Number of preset slots; slot 0 of the store is never written or loaded.
  localparam int PresetSlots   = 8;
  localparam int PresetDepth   = PresetSlots + 1;
  localparam int SlotIdxW      = $clog2(PresetDepth);
  localparam int ChoiceW       = 5;
  localparam int ChoiceCapInt  = (2 * PresetSlots > 31) ? 31 : 2 * PresetSlots;
  localparam logic [ChoiceW-1:0] ChoiceCap = ChoiceW'(ChoiceCapInt);

  localparam int LevelW        = 8;
  localparam int TimeW         = 32;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 8;

  localparam logic [CfgDataW-1:0] DebounceMsRst = 8'd15;
  localparam logic [CfgDataW-1:0] LevelMaxRst   = 8'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounceMs = 1'b0,
    CfgLevelMax   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ItemRed    = 3'd0,
    ItemGreen  = 3'd1,
    ItemBlue   = 3'd2,
    ItemOn     = 3'd3,
    ItemPreset = 3'd4
  } menu_item_e;

  typedef struct packed {
    logic             phase_i;
    logic             phase_q;
    logic             button_level;
    logic [TimeW-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0]  red_level;
    logic [LevelW-1:0]  green_level;
    logic [LevelW-1:0]  blue_level;
    logic               light_on;
    logic [2:0]         menu_item;
    logic [ChoiceW-1:0] slot_choice;
  } out_item_t;

  // One detent event from the quadrature decoder.
  typedef struct packed {
    logic up;
    logic down;
  } detent_t;

  // Gray-code transition table, indexed by {previous phases, current phases}.
  function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/remc_quad.sv =====
// ----------------------------------------------------------------------------
// remc_quad: quadrature step decoder
// Accumulates Gray-code steps and flags a detent every four steps.
// ----------------------------------------------------------------------------
module remc_quad (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [1:0]        phases_i,
  output remc_pkg::detent_t detent_o
);
  import remc_pkg::*;

  logic [1:0]        last_q, last_d;
  logic signed [3:0] acc_q, acc_d;
  logic signed [1:0] step;
  logic signed [3:0] sum;

  always_comb begin
    step = gray_step({last_q, phases_i});
    sum  = acc_q + {{2{step[1]}}, step};
    last_d = (step != 2'sd0) ? phases_i : last_q;
    detent_o = '0;
    acc_d = sum;
    if (sum >= 4'sd4) begin
      detent_o.up = 1'b1;
      acc_d = sum - 4'sd4;
    end else if (sum <= -4'sd4) begin
      detent_o.down = 1'b1;
      acc_d = sum + 4'sd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 2'b11;
      acc_q  <= '0;
    end else if (en_i) begin
      last_q <= last_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// ===== rtl/remc_debounce.sv =====
// ----------------------------------------------------------------------------
// remc_debounce: button debouncer
// Accepts a new button level once it has held for the debounce time.
// ----------------------------------------------------------------------------
module remc_debounce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              button_i,
  input  logic [remc_pkg::TimeW-1:0]        time_i,
  input  logic [remc_pkg::CfgDataW-1:0]     debounce_ms_i,
  output logic                              press_o
);
  import remc_pkg::*;

  logic             last_q, last_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_q, change_d;
  logic [TimeW-1:0] elapsed;

  always_comb begin
    elapsed  = time_i - change_q;
    last_d   = last_q;
    stable_d = stable_q;
    change_d = change_q;
    press_o  = 1'b0;
    if (button_i != last_q) begin
      // Restart the timer on any edge.
      change_d = time_i;
      last_d   = button_i;
    end else if (button_i != stable_q &&
                 elapsed >= {{(TimeW-CfgDataW){1'b0}}, debounce_ms_i}) begin
      stable_d = button_i;
      press_o  = ~button_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      change_q <= '0;
    end else if (en_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      change_q <= change_d;
    end
  end

endmodule

// ===== rtl/remc_menu.sv =====
// ----------------------------------------------------------------------------
// remc_menu: menu state and preset store
// Applies detents and presses to levels, on flag, item and preset choice.
// ----------------------------------------------------------------------------
module remc_menu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  remc_pkg::detent_t             detent_i,
  input  logic                          press_i,
  input  logic [remc_pkg::LevelW-1:0]   level_max_i,
  output remc_pkg::out_item_t           state_o
);
  import remc_pkg::*;

  logic [LevelW-1:0]    color_q [3];
  logic [LevelW-1:0]    color_d [3];
  logic                 on_q, on_d;
  menu_item_e           item_q, item_d;
  logic [ChoiceW-1:0]   choice_q, choice_d;
  logic [3*LevelW-1:0]  store_q [PresetDepth];

  logic [1:0]           cidx;
  logic [ChoiceW:0]     slot_sum;
  logic [ChoiceW-1:0]   slot;
  logic [SlotIdxW-1:0]  slot_idx;
  logic                 slot_ok;
  logic                 save_en;
  logic [3*LevelW-1:0]  save_word;
  logic [3*LevelW-1:0]  load_word;

  always_comb begin
    color_d  = color_q;
    on_d     = on_q;
    item_d   = item_q;
    choice_d = choice_q;
    cidx     = item_q[1:0];
    save_en  = 1'b0;

    // Detent acts first.
    if (detent_i.up || detent_i.down) begin
      unique case (item_q)
        ItemRed, ItemGreen, ItemBlue: begin
          if (detent_i.up) begin
            if (color_q[cidx] < level_max_i) color_d[cidx] = color_q[cidx] + 1'b1;
          end else if (color_q[cidx] != '0) begin
            color_d[cidx] = color_q[cidx] - 1'b1;
          end
        end
        ItemOn: on_d = detent_i.up;
        ItemPreset: begin
          if (detent_i.up) begin
            if (choice_q < ChoiceCap) choice_d = choice_q + 1'b1;
          end else if (choice_q != '0) begin
            choice_d = choice_q - 1'b1;
          end
        end
        default: ;
      endcase
    end

    slot_sum  = {1'b0, choice_d} + 1'b1;
    slot      = slot_sum[ChoiceW:1];
    slot_idx  = slot[SlotIdxW-1:0];
    slot_ok   = (slot != '0) && ({27'b0, slot} <= 32'(PresetSlots));
    save_word = {color_d[2], color_d[1], color_d[0]};
    load_word = store_q[slot_idx];

    // Then the press: step to the next item; leaving the preset item saves or loads on the way.
    if (press_i) begin
      if (item_q == ItemPreset && choice_d != '0) begin
        if (slot_ok) begin
          if (!choice_d[0]) begin
            save_en = 1'b1;
          end else begin
            color_d[0] = load_word[LevelW-1:0];
            color_d[1] = load_word[2*LevelW-1:LevelW];
            color_d[2] = load_word[3*LevelW-1:2*LevelW];
          end
        end
        choice_d = '0;
      end
      unique case (item_q)
        ItemRed:    item_d = ItemGreen;
        ItemGreen:  item_d = ItemBlue;
        ItemBlue:   item_d = ItemOn;
        ItemOn:     item_d = ItemPreset;
        ItemPreset: item_d = ItemRed;
        default:    item_d = ItemRed;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) color_q[k] <= '0;
      for (int k = 0; k < PresetDepth; k++) store_q[k] <= '0;
      on_q     <= 1'b0;
      item_q   <= ItemRed;
      choice_q <= '0;
    end else if (en_i) begin
      color_q  <= color_d;
      on_q     <= on_d;
      item_q   <= item_d;
      choice_q <= choice_d;
      if (save_en) store_q[slot_idx] <= save_word;
    end
  end

  assign state_o.red_level   = color_q[0];
  assign state_o.green_level = color_q[1];
  assign state_o.blue_level  = color_q[2];
  assign state_o.light_on    = on_q;
  assign state_o.menu_item   = item_q;
  assign state_o.slot_choice = choice_q;

endmodule

// ===== rtl/rotary_encoder_menu_control.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_menu_control: encoder and button menu for an RGB light
// Decodes quadrature detents and debounced presses into menu state updates.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction in gives one transaction out, through the input register and
// then the menu state; one item per cycle sustained while out is not stalled.
// Stage 1 is the input register; the update logic between it and the menu
// state (which doubles as the result register) is the only path of note.
// A stall on out holds the result and backs up into the input register;
// in_ready_o drops only when both registers are full and out is stalled.
// Reset clears the preset store and all state bar the input payload at once; no sweep is needed.
// cfg is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module rotary_encoder_menu_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  remc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output remc_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [remc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [remc_pkg::CfgDataW-1:0] cfg_data_i
);
  import remc_pkg::*;

  // Input register.
  logic       in_valid_q, in_valid_d;
  in_item_t   in_data_q;
  // Result valid; the payload is the menu state itself.
  logic       out_valid_q, out_valid_d;
  logic       advance;
  logic       in_accept;

  logic [CfgDataW-1:0] debounce_q;
  logic [CfgDataW-1:0] level_max_q;

  detent_t    detent;
  logic       press;

  // Advance stage 1 into the state whenever the result slot frees up.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)    in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) in_data_q <= in_data_i;
  end

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceMsRst;
      level_max_q <= LevelMaxRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgDebounceMs: debounce_q  <= cfg_data_i;
        CfgLevelMax:   level_max_q <= cfg_data_i;
      endcase
    end
  end

  remc_quad u_quad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .phases_i ({in_data_q.phase_i, in_data_q.phase_q}),
    .detent_o (detent)
  );

  remc_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .button_i      (in_data_q.button_level),
    .time_i        (in_data_q.time_ms),
    .debounce_ms_i (debounce_q),
    .press_o       (press)
  );

  // Menu state updates only on advance, so while out is valid it holds
  // exactly the result of the last item.
  remc_menu u_menu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .detent_i    (detent),
    .press_i     (press),
    .level_max_i (level_max_q),
    .state_o     (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/remc_checker.sv =====
// ----------------------------------------------------------------------------
// remc_checker: port-level checks for rotary_encoder_menu_control
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module remc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input remc_pkg::out_item_t           out_data_o
);
  import remc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Empty result slot never blocks the input.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result slot");

  a_item_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.menu_item <= ItemPreset)
    else $error("menu item out of range");

  a_choice_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.slot_choice <= ChoiceCap)
    else $error("slot choice above cap");

  // A pending choice only exists while the preset item is selected.
  a_choice_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.slot_choice != '0 |-> out_data_o.menu_item == ItemPreset)
    else $error("slot choice pending outside preset item");

endmodule

bind rotary_encoder_menu_control remc_checker u_remc_checker (.*);
